FILE: design/lpfd_pkg.sv
package lpfd_pkg;

    localparam int LENGTH_FIELD_BYTES_DEF = 4;
    localparam int OPCODE_FIELD_BYTES_DEF = 4;
    localparam logic [15:0] MAX_PAYLOAD_LENGTH_RESET = 16'd4088;

    typedef enum logic [1:0] {
        ST_PAYLOAD  = 2'd0,
        ST_ZERO_LEN = 2'd1,
        ST_TOO_LONG = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [31:0] frame_opcode;
        logic [15:0] frame_length;
        logic        last_of_frame;
        status_t     status;
    } result_t;

    typedef struct packed {
        logic halted;
        logic in_payload;
    } parse_status_t;

endpackage

FILE: design/lpfd_parser.sv
module lpfd_parser
    import lpfd_pkg::*;
#(
    parameter int LENGTH_FIELD_BYTES = LENGTH_FIELD_BYTES_DEF,
    parameter int OPCODE_FIELD_BYTES = OPCODE_FIELD_BYTES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    byte_in,
    input  logic [15:0]   max_len,
    output logic          res_valid,
    output result_t       res,
    output parse_status_t parse_status
);

    localparam int LEN_W     = 8 * LENGTH_FIELD_BYTES;
    localparam int OP_W      = 8 * OPCODE_FIELD_BYTES;
    localparam int HDR_BYTES = LENGTH_FIELD_BYTES + OPCODE_FIELD_BYTES;

    logic [2:0]       header_count_reg, header_count_next;
    logic             in_payload_reg, in_payload_next;
    logic [LEN_W-1:0] length_accum_reg, length_accum_next;
    logic [OP_W-1:0]  opcode_accum_reg, opcode_accum_next;
    logic [15:0]      remaining_reg, remaining_next;
    logic             halted_reg, halted_next;

    always_comb
    begin
        header_count_next = header_count_reg;
        in_payload_next   = in_payload_reg;
        length_accum_next = length_accum_reg;
        opcode_accum_next = opcode_accum_reg;
        remaining_next    = remaining_reg;
        halted_next       = halted_reg;
        res_valid         = 1'b0;
        res.payload_byte  = byte_in;
        res.frame_opcode  = 32'(opcode_accum_reg);
        res.frame_length  = 16'(length_accum_reg);
        res.last_of_frame = (remaining_reg <= 16'd1);
        res.status        = ST_PAYLOAD;

        if (step && !halted_reg)
        begin
            if (!in_payload_reg)
            begin
                // Each header byte lands in its own lane; every lane is rewritten per frame.
                for (int i = 0; i < LENGTH_FIELD_BYTES; i++)
                begin
                    if (header_count_reg == 3'(i))
                        length_accum_next[8*i +: 8] = byte_in;
                end
                for (int i = 0; i < OPCODE_FIELD_BYTES; i++)
                begin
                    if (header_count_reg == 3'(LENGTH_FIELD_BYTES + i))
                        opcode_accum_next[8*i +: 8] = byte_in;
                end

                if (header_count_reg == 3'(HDR_BYTES - 1))
                begin
                    header_count_next = 3'd0;
                    res.payload_byte  = 8'd0;
                    res.frame_opcode  = 32'(opcode_accum_next);
                    res.frame_length  = 16'd0;
                    res.last_of_frame = 1'b0;
                    if (length_accum_next == '0)
                    begin
                        halted_next = 1'b1;
                        res_valid   = 1'b1;
                        res.status  = ST_ZERO_LEN;
                    end
                    else if (32'(length_accum_next) > 32'(max_len))
                    begin
                        halted_next = 1'b1;
                        res_valid   = 1'b1;
                        res.status  = ST_TOO_LONG;
                    end
                    else
                    begin
                        in_payload_next = 1'b1;
                        remaining_next  = 16'(length_accum_next);
                    end
                end
                else
                begin
                    header_count_next = header_count_reg + 3'd1;
                end
            end
            else
            begin
                res_valid = 1'b1;
                if (res.last_of_frame)
                    in_payload_next = 1'b0;
                else
                    remaining_next = remaining_reg - 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg <= 3'd0;
            in_payload_reg   <= 1'b0;
            length_accum_reg <= '0;
            opcode_accum_reg <= '0;
            remaining_reg    <= 16'd0;
            halted_reg       <= 1'b0;
        end
        else
        begin
            header_count_reg <= header_count_next;
            in_payload_reg   <= in_payload_next;
            length_accum_reg <= length_accum_next;
            opcode_accum_reg <= opcode_accum_next;
            remaining_reg    <= remaining_next;
            halted_reg       <= halted_next;
        end
    end

    assign parse_status.halted     = halted_reg;
    assign parse_status.in_payload = in_payload_reg;

endmodule

FILE: design/lpfd_out_queue.sv
module lpfd_out_queue
    import lpfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    has_space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t head
);

    result_t    entries_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign has_space = (count_reg != 2'd2);
    assign pop       = out_valid && out_ready;
    assign head      = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/length_prefixed_frame_deframer_top.sv
// A payload byte or error transaction passes the input register, then is parsed into a
// two-entry output queue. Throughput: one byte per cycle while the queue has space;
// the output queue takes a result while the previous one waits.
// Reset (rst_n, asynchronous, active low) clears the parser, the queue and sets the
// maximum payload length to 4088. After an error the block drops all bytes until reset.
module length_prefixed_frame_deframer_top
    import lpfd_pkg::*;
#(
    parameter int LENGTH_FIELD_BYTES = LENGTH_FIELD_BYTES_DEF,
    parameter int OPCODE_FIELD_BYTES = OPCODE_FIELD_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  payload_byte,
    output logic [31:0] frame_opcode,
    output logic [15:0] frame_length,
    output logic        last_of_frame,
    output logic [1:0]  status
);

    logic [15:0]   max_len_reg;
    logic          in_vld_reg, in_vld_next;
    logic [7:0]    byte_reg;
    logic          step;
    logic          res_valid;
    result_t       res;
    result_t       head;
    logic          has_space;
    parse_status_t parse_status;

    // The queue's space is registered, so no path runs from out_ready to in_ready.
    assign step     = in_vld_reg && has_space;
    assign in_ready = !in_vld_reg || has_space;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_ready)
            in_vld_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_PAYLOAD_LENGTH_RESET;
            in_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                max_len_reg <= cfg_wr_data;
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= data_byte;
    end

    lpfd_parser #(
        .LENGTH_FIELD_BYTES (LENGTH_FIELD_BYTES),
        .OPCODE_FIELD_BYTES (OPCODE_FIELD_BYTES)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .byte_in      (byte_reg),
        .max_len      (max_len_reg),
        .res_valid    (res_valid),
        .res          (res),
        .parse_status (parse_status)
    );

    lpfd_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .has_space (has_space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign payload_byte  = head.payload_byte;
    assign frame_opcode  = head.frame_opcode;
    assign frame_length  = head.frame_length;
    assign last_of_frame = head.last_of_frame;
    assign status        = head.status;

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        parse_status.halted |=> parse_status.halted)
        else $error("halt state cleared without reset");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        parse_status.halted |-> !res_valid)
        else $error("result produced while halted");

    a_halt_exit_payload: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(parse_status.halted) |-> !parse_status.in_payload)
        else $error("halt raised during payload reception");

    a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_frame |-> status == ST_PAYLOAD)
        else $error("last-of-frame mark on an error transaction");

    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled while the output queue is empty");

endmodule

FILE: test/length_prefixed_frame_deframer_top_test.sv
class frame_tracker;
    logic [15:0]        max_len;
    int unsigned        hdr_count;
    logic               in_payload;
    logic [31:0]        len_acc;
    logic [31:0]        op_acc;
    logic [15:0]        remaining;
    logic               halted;
    lpfd_pkg::result_t  results_due[$];
    int unsigned        bytes_taken;
    int unsigned        payload_results;
    int unsigned        error_results;
    int unsigned        failures;

    function new();
        max_len = lpfd_pkg::MAX_PAYLOAD_LENGTH_RESET;
        halted = 1'b0;
        bytes_taken = 0;
        payload_results = 0;
        error_results = 0;
        failures = 0;
        clear_frame();
    endfunction

    function void clear_frame();
        hdr_count = 0;
        in_payload = 1'b0;
        len_acc = '0;
        op_acc = '0;
        remaining = '0;
    endfunction

    function void set_max_length(logic [15:0] v);
        max_len = v;
    endfunction

    function int unsigned pending();
        return results_due.size();
    endfunction

    function void push_error(lpfd_pkg::status_t code);
        lpfd_pkg::result_t r;
        r.payload_byte = '0;
        r.frame_opcode = op_acc;
        r.frame_length = '0;
        r.last_of_frame = 1'b0;
        r.status = code;
        halted = 1'b1;
        results_due.push_back(r);
    endfunction

    // Called once per accepted input transaction.
    function void take_byte(logic [7:0] b);
        lpfd_pkg::result_t r;
        bytes_taken++;
        if (halted)
            return;
        if (!in_payload) begin
            if (hdr_count < 4)
                len_acc = len_acc | ({24'd0, b} << (8 * hdr_count));
            else
                op_acc = op_acc | ({24'd0, b} << (8 * (hdr_count - 4)));
            hdr_count++;
            if (hdr_count < 8)
                return;
            hdr_count = 0;
            // The limit check is made against the full 32-bit length field.
            if (len_acc == 32'd0)
                push_error(lpfd_pkg::ST_ZERO_LEN);
            else if (len_acc > {16'd0, max_len})
                push_error(lpfd_pkg::ST_TOO_LONG);
            else
            begin
                in_payload = 1'b1;
                remaining = len_acc[15:0];
            end
            return;
        end
        r.payload_byte = b;
        r.frame_opcode = op_acc;
        r.frame_length = len_acc[15:0];
        r.last_of_frame = (remaining <= 16'd1);
        r.status = lpfd_pkg::ST_PAYLOAD;
        results_due.push_back(r);
        if (r.last_of_frame)
            clear_frame();
        else
            remaining = remaining - 16'd1;
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] seen,
                         longint unsigned stamp);
        $display("%0t: %s mismatch, expected %0h, actual %0h", stamp, field, want, seen);
        failures++;
    endfunction

    function void check_result(lpfd_pkg::result_t got, longint unsigned stamp);
        lpfd_pkg::result_t want;
        if (results_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual byte %0h opcode %0h",
                     stamp, got.payload_byte, got.frame_opcode);
            $display("%0t: unexpected result, actual length %0d last %0b status %0d",
                     stamp, got.frame_length, got.last_of_frame, got.status);
            failures++;
            return;
        end
        want = results_due.pop_front();
        if (want.status == lpfd_pkg::ST_PAYLOAD)
            payload_results++;
        else
            error_results++;
        if (got.payload_byte !== want.payload_byte)
            report("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte), stamp);
        if (got.frame_opcode !== want.frame_opcode)
            report("frame_opcode", want.frame_opcode, got.frame_opcode, stamp);
        if (got.frame_length !== want.frame_length)
            report("frame_length", 32'(want.frame_length), 32'(got.frame_length), stamp);
        if (got.last_of_frame !== want.last_of_frame)
            report("last_of_frame", 32'(want.last_of_frame), 32'(got.last_of_frame), stamp);
        if (got.status !== want.status)
            report("status", 32'(want.status), 32'(got.status), stamp);
    endfunction
endclass

module length_prefixed_frame_deframer_top_test;
    import lpfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  payload_byte;
    logic [31:0] frame_opcode;
    logic [15:0] frame_length;
    logic        last_of_frame;
    logic [1:0]  status;

    frame_tracker sb;
    result_t      seen;
    int           idle_cycles = 0;
    int           burst_left = 0;
    int           frames_sent = 0;
    int           limits_used = 0;
    bit           timed_out = 1'b0;
    string        ending = "no error frame";

    length_prefixed_frame_deframer_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .payload_byte  (payload_byte),
        .frame_opcode  (frame_opcode),
        .frame_length  (frame_length),
        .last_of_frame (last_of_frame),
        .status        (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (in_valid && in_ready)
            sb.take_byte(data_byte);
        if (out_valid && out_ready) begin
            seen.payload_byte = payload_byte;
            seen.frame_opcode = frame_opcode;
            seen.frame_length = frame_length;
            seen.last_of_frame = last_of_frame;
            seen.status = status_t'(status);
            sb.check_result(seen, $time);
        end
    end

    // The receiver cycles through modes: always ready, coin flip, one in four,
    // and a long stall that always ends in a ready stretch.
    initial
    begin
        int mode;
        int mode_left;
        int step;
        mode = 0;
        mode_left = 0;
        step = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(40, 120);
                step = 0;
            end
            mode_left--;
            step++;
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= (step % 4 == 0);
                default: out_ready <= (step > 30);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 32);
            repeat (gap) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_header(input logic [31:0] len, input logic [31:0] op);
        frames_sent++;
        for (int i = 0; i < 4; i++)
            send_byte(len[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            send_byte(op[8*i +: 8]);
    endtask

    task automatic send_frame(input logic [31:0] len);
        send_header(len, $urandom);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // Header bytes give no result, so spare cycles follow the last expected one.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_length(input logic [15:0] v);
        wait_drained();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_max_length(v);
        limits_used++;
    endtask

    function automatic int pick_length(input logic [15:0] lim);
        int r;
        int cap;
        r = $urandom_range(0, 19);
        if (r == 19 && lim <= 600)
            return int'(lim);
        cap = (r < 14) ? 12 : ((r < 18) ? 64 : 600);
        if (cap > lim)
            cap = int'(lim);
        return $urandom_range(1, cap);
    endfunction

    task automatic run_traffic();
        logic [15:0] phase_max [7];
        logic [31:0] bad_len;
        int          phase_bytes;
        int          kind;
        int          len;

        // Extremes of payload and opcode under the reset limit, then frames under a limit of one.
        send_header(32'd1, 32'h0000_0000);
        send_byte(8'h00);
        send_header(32'd1, 32'hFFFF_FFFF);
        send_byte(8'hFF);
        write_max_length(16'd1);
        send_frame(32'd1);
        send_frame(32'd1);

        phase_max[0] = 16'd7;
        phase_max[1] = 16'd65535;
        phase_max[2] = 16'd2;
        phase_max[3] = 16'($urandom_range(3, 40));
        phase_max[4] = 16'($urandom_range(300, 4000));
        phase_max[5] = 16'd256;
        phase_max[6] = 16'($urandom_range(1, 65535));
        foreach (phase_max[p]) begin
            write_max_length(phase_max[p]);
            phase_bytes = 0;
            while (phase_bytes < 80) begin
                len = pick_length(phase_max[p]);
                send_frame(len);
                phase_bytes += len + 8;
            end
        end

        // Only one error can be seen per reset, so the run ends on one of them.
        kind = $urandom_range(0, 2);
        if (kind == 0) begin
            ending = "a zero-length frame";
            send_header(32'd0, $urandom);
        end
        else if (kind == 1) begin
            write_max_length(16'($urandom_range(1, 65535)));
            bad_len = {16'd0, sb.max_len} + 32'd1;
            if (sb.max_len == 16'd65535 || $urandom_range(0, 1) == 1)
                bad_len = {16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535))};
            ending = "a frame above the length limit";
            send_header(bad_len, $urandom);
        end
        else
        begin
            write_max_length(16'd0);
            ending = "a frame under a zero length limit";
            send_header($urandom_range(1, 65535), $urandom);
        end
        // Everything after the error is dropped.
        send_frame(32'd1);
        repeat (12)
            send_byte(8'($urandom_range(0, 255)));
        wait_drained();
        repeat (8) @(posedge clk);
    endtask

    task automatic watch_progress();
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        timed_out = 1'b1;
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        data_byte = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        fork
            run_traffic();
            watch_progress();
        join_any
        disable fork;
        $display("Sent %0d bytes in %0d frames over %0d length limit settings.",
                 sb.bytes_taken, frames_sent, limits_used);
        $display("Checked %0d payload and %0d error results; the stream ended with %s.",
                 sb.payload_results, sb.error_results, ending);
        if (!timed_out && sb.failures == 0 && sb.pending() == 0)
            $display("length_prefixed_frame_deframer_top_test: PASS");
        else
            $display("length_prefixed_frame_deframer_top_test: FAIL");
        $finish;
    end
endmodule

FILE: files.f
design/lpfd_pkg.sv
design/lpfd_parser.sv
design/lpfd_out_queue.sv
design/length_prefixed_frame_deframer_top.sv
test/length_prefixed_frame_deframer_top_test.sv
